// ===== sv/mspid_pkg.sv =====
package mspid_pkg;

    localparam logic [1:0] REQ_EDGE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_STOP   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_INTEG_LIM  = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIM  = 3'd4;
    localparam logic [2:0] REG_DEADBAND   = 3'd5;

    // 6000 rpm per turn/min times 16 for the Q12.4 result
    localparam logic signed [17:0] SPEED_SCALE = 18'sd96000;
    localparam int FRAC_BITS = 12;

    localparam int MUL_AW = 33;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 16;
    localparam int DIV_QW = 28;
    localparam int DIV_CW = 5;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [15:0] integ_limit;
        logic [9:0]  drive_limit;
        logic [11:0] error_deadband;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

endpackage

// ===== sv/mspid_cfg.sv =====
module mspid_cfg
    import mspid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= 16'd614;
            cfg_reg.integ_gain     <= 16'd46;
            cfg_reg.deriv_gain     <= 16'd77;
            cfg_reg.integ_limit    <= 16'd1000;
            cfg_reg.drive_limit    <= 10'd800;
            cfg_reg.error_deadband <= 12'd5;
        end
        else if (wr)
        begin
            case (idx)
                REG_PROP_GAIN:  cfg_reg.prop_gain      <= pwdata[15:0];
                REG_INTEG_GAIN: cfg_reg.integ_gain     <= pwdata[15:0];
                REG_DERIV_GAIN: cfg_reg.deriv_gain     <= pwdata[15:0];
                REG_INTEG_LIM:  cfg_reg.integ_limit    <= pwdata[15:0];
                REG_DRIVE_LIM:  cfg_reg.drive_limit    <= pwdata[9:0];
                REG_DEADBAND:   cfg_reg.error_deadband <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PROP_GAIN:  prdata = {16'd0, cfg_reg.prop_gain};
            REG_INTEG_GAIN: prdata = {16'd0, cfg_reg.integ_gain};
            REG_DERIV_GAIN: prdata = {16'd0, cfg_reg.deriv_gain};
            REG_INTEG_LIM:  prdata = {16'd0, cfg_reg.integ_limit};
            REG_DRIVE_LIM:  prdata = {22'd0, cfg_reg.drive_limit};
            REG_DEADBAND:   prdata = {20'd0, cfg_reg.error_deadband};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/mspid_mul.sv =====
module mspid_mul
    import mspid_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_AW-1:0] a,
    input  logic signed [MUL_BW-1:0] b,
    output logic signed [MUL_PW-1:0] prod
);

    logic signed [MUL_PW-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

endmodule

// ===== sv/mspid_div.sv =====
module mspid_div
    import mspid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              done,
    output logic [DIV_QW-1:0] quot
);

    // restoring divide, one quotient bit per cycle; needs dividend < divisor << iters
    logic [DIV_NW-1:0]        rem_reg;
    logic [DIV_DW+DIV_QW-2:0] dsh_reg;
    logic [DIV_QW-1:0]        q_reg;
    logic [DIV_CW-1:0]        cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_NW-1:0]        dsh_ext;
    logic                     fits;

    assign dsh_ext = DIV_NW'(dsh_reg);
    assign fits    = rem_reg >= dsh_ext;
    assign done    = done_reg;
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsh_reg <= (DIV_DW+DIV_QW-1)'(req.divisor) << (req.iters - 1'b1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_ext;
            end
            q_reg   <= {q_reg[DIV_QW-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

// ===== sv/motor_speed_pid_loop_top.sv =====
// Motor speed loop: encoder edge counter, speed measurement, moving
// average and positional PID with dead zone, sign/magnitude drive.
// Input channel (in_valid/in_stall): req_type 0 = encoder edge, 1 = control
// tick with target_speed, 2 = stop; code 3 is dropped. Output channel
// (out_valid/out_stall) carries one word per tick or stop, none per edge.
// An edge stays in idle and the next word is taken the cycle after.
// A tick runs a sequencer over one shared multiplier and one restoring
// divider: speed multiply, raw speed (skipped when it saturates), history,
// average, dead zone, integral with its clamp (28 divider steps when the
// clamp fires), gain terms and output clamp. Divisions by pulses per turn
// and by the tap count use two-pass reciprocal multiplies. A stop clears
// the integral and goes straight to the emit step; in_stall is high while
// a word is in work. The result sits in an output register; the next word
// is accepted while it waits, but a further tick or stop holds in its last
// step until the receiver drops out_stall. Reset clears counters, history,
// integral and previous error and loads the default gains and limits;
// config writes go through the APB port at 4*index with pready tied high.
module motor_speed_pid_loop_top
    import mspid_pkg::*;
#(
    parameter int PULSES_PER_TURN = 1024,
    parameter int AVERAGE_TAPS    = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic               encoder_dir,
    input  logic signed [15:0] target_speed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         duty_magnitude,
    output logic               drive_reverse,
    output logic signed [15:0] measured_speed,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SUMW = 17 + $clog2(AVERAGE_TAPS);
    localparam logic [47:0] SAT_NUM = 48'(PULSES_PER_TURN) << 16;

    // floor(n / d) = (n * m) >> sh for n < 2^32, m = ceil(2^sh / d)
    localparam int SPD_SH = 32 + $clog2(PULSES_PER_TURN);
    localparam int AVG_SH = 32 + $clog2(AVERAGE_TAPS);
    localparam logic [33:0] SPD_M = 34'(((64'd1 << SPD_SH) + 64'(PULSES_PER_TURN)
                                         - 64'd1) / 64'(PULSES_PER_TURN));
    localparam logic [33:0] AVG_M = 34'(((64'd1 << AVG_SH) + 64'(AVERAGE_TAPS)
                                         - 64'd1) / 64'(AVERAGE_TAPS));

    typedef enum logic [4:0] {
        S_IDLE, S_SPD_MUL, S_SPD_CHK, S_RLO, S_RHI, S_RFIN, S_HIST, S_AVG,
        S_ERR, S_IMUL, S_ICHK, S_IDIV, S_IFIN, S_MP, S_MI, S_MD, S_ACC,
        S_OUT, S_EMIT
    } state_t;

    cfg_t cfg;

    state_t                   state_reg, state_next;
    logic [31:0]              pulse_reg;
    logic [31:0]              prev_cnt_reg;
    logic signed [15:0]       hist_reg [AVERAGE_TAPS];
    logic signed [SUMW-1:0]   sum_reg;
    logic signed [31:0]       integral_reg;
    logic signed [16:0]       prev_err_reg;
    logic signed [15:0]       target_reg;
    logic [31:0]              mag_reg;
    logic                     neg_reg;
    logic signed [15:0]       raw_reg;
    logic signed [15:0]       speed_reg;
    logic signed [16:0]       err_reg;
    logic signed [31:0]       integ_reg;
    logic signed [MUL_PW-1:0] acc_reg;
    logic [9:0]               duty_res_reg;
    logic                     rev_res_reg;
    logic                     out_valid_reg;
    logic [9:0]               duty_reg;
    logic                     rev_reg;
    logic signed [15:0]       meas_reg;
    logic [31:0]              num_reg;
    logic [48:0]              rlo_reg;
    logic                     rsel_reg;

    logic                     in_acc;
    logic                     out_free;
    logic [31:0]              delta;
    logic                     mul_en;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] prod;
    div_req_t                 dreq;
    logic                     div_done;
    logic [DIV_QW-1:0]        quot;
    logic [47:0]              prod_u;
    logic [SUMW-1:0]          sum_mag;
    logic signed [16:0]       err_raw;
    logic signed [17:0]       band_s;
    logic signed [32:0]       integ_sum;
    logic signed [31:0]       integ_sat;
    logic signed [MUL_PW-1:0] lim_s;
    logic [27:0]              lim;
    logic signed [17:0]       derr;
    logic signed [MUL_PW-1:0] dlim_s;
    logic signed [22:0]       out_c;
    logic [22:0]              out_mag;
    logic signed [32:0]       q_s33;
    logic                     spd_sat;
    logic [16:0]              m_lo;
    logic [16:0]              m_hi;
    logic [48:0]              rsum;
    logic [16:0]              rq;
    logic signed [16:0]       rq_s;

    mspid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mspid_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mspid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quot  (quot)
    );

    assign in_stall       = (state_reg != S_IDLE);
    assign in_acc         = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign duty_magnitude = duty_reg;
    assign drive_reverse  = rev_reg;
    assign measured_speed = meas_reg;

    assign delta   = pulse_reg - prev_cnt_reg;
    assign prod_u  = prod[47:0];
    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign lim     = {cfg.integ_limit, 12'd0};
    assign lim_s   = MUL_PW'(signed'({1'b0, lim}));
    assign q_s33   = signed'(33'(quot));
    assign spd_sat = (prod_u >= SAT_NUM);

    // reciprocal: low half of m in one pass, high half in the next
    assign m_lo = rsel_reg ? AVG_M[16:0] : SPD_M[16:0];
    assign m_hi = rsel_reg ? AVG_M[33:17] : SPD_M[33:17];
    assign rsum = {1'b0, prod[47:0]} + 49'(rlo_reg[48:17]);
    assign rq   = rsel_reg ? 17'(rsum >> (AVG_SH - 17)) : 17'(rsum >> (SPD_SH - 17));
    assign rq_s = signed'(rq);

    assign err_raw   = 17'(target_reg) - 17'(speed_reg);
    assign band_s    = signed'({6'd0, cfg.error_deadband});
    assign integ_sum = 33'(integral_reg) + 33'(err_reg);
    assign integ_sat = (integ_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                       (integ_sum < -33'sh0_8000_0000) ? -32'sh8000_0000 :
                       32'(integ_sum);
    assign derr      = 18'(err_reg) - 18'(prev_err_reg);
    assign dlim_s    = MUL_PW'(signed'({1'b0, cfg.drive_limit, 12'd0}));
    assign out_c     = (acc_reg > dlim_s) ? 23'(dlim_s) :
                       (acc_reg < -dlim_s) ? 23'(-dlim_s) : 23'(acc_reg);
    assign out_mag   = out_c[22] ? 23'(-out_c) : 23'(out_c);

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_SPD_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, mag_reg});
                mul_b  = SPEED_SCALE;
            end
            S_RLO:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, num_reg});
                mul_b  = signed'({1'b0, m_lo});
            end
            S_RHI:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({1'b0, num_reg});
                mul_b  = signed'({1'b0, m_hi});
            end
            S_IMUL:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(integ_sat);
                mul_b  = signed'({2'b00, cfg.integ_gain});
            end
            S_MI:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(integ_reg);
                mul_b  = signed'({2'b00, cfg.integ_gain});
            end
            S_MP:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(err_reg);
                mul_b  = signed'({2'b00, cfg.prop_gain});
            end
            S_MD:
            begin
                mul_en = 1'b1;
                mul_a  = 33'(derr);
                mul_b  = signed'({2'b00, cfg.deriv_gain});
            end
            default: ;
        endcase
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.iters    = DIV_CW'(DIV_QW);
        dreq.dividend = DIV_NW'(lim);
        dreq.divisor  = cfg.integ_gain;
        case (state_reg)
            S_ICHK:
            begin
                dreq.start = (prod > lim_s) || (prod < -lim_s);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && req_type == REQ_TICK)
                begin
                    state_next = S_SPD_MUL;
                end
                else if (in_acc && req_type == REQ_STOP)
                begin
                    state_next = S_EMIT;
                end
            end
            S_SPD_MUL: state_next = S_SPD_CHK;
            S_SPD_CHK: state_next = spd_sat ? S_HIST : S_RLO;
            S_RLO:     state_next = S_RHI;
            S_RHI:     state_next = S_RFIN;
            S_RFIN:    state_next = rsel_reg ? S_ERR : S_HIST;
            S_HIST:    state_next = S_AVG;
            S_AVG:     state_next = S_RLO;
            S_ERR:     state_next = S_IMUL;
            S_IMUL:    state_next = S_ICHK;
            S_ICHK:    state_next = dreq.start ? S_IDIV : S_IFIN;
            S_IDIV:    state_next = div_done ? S_IFIN : S_IDIV;
            S_IFIN:    state_next = S_MP;
            S_MP:      state_next = S_MI;
            S_MI:      state_next = S_MD;
            S_MD:      state_next = S_ACC;
            S_ACC:     state_next = S_OUT;
            S_OUT:     state_next = S_EMIT;
            S_EMIT:    state_next = out_free ? S_IDLE : S_EMIT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pulse_reg     <= '0;
            prev_cnt_reg  <= '0;
            sum_reg       <= '0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AVERAGE_TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (req_type)
                            REQ_EDGE:
                            begin
                                pulse_reg <= encoder_dir ? pulse_reg + 1'b1
                                                         : pulse_reg - 1'b1;
                            end
                            REQ_TICK:
                            begin
                                prev_cnt_reg <= pulse_reg;
                            end
                            REQ_STOP:
                            begin
                                integral_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_HIST:
                begin
                    // running sum tracks the window: add newest, drop oldest
                    sum_reg <= sum_reg + SUMW'(raw_reg)
                             - SUMW'(hist_reg[AVERAGE_TAPS-1]);
                    for (int i = AVERAGE_TAPS - 1; i > 0; i--)
                    begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                    hist_reg[0] <= raw_reg;
                end
                S_IFIN:
                begin
                    integral_reg <= (target_reg == 16'sd0) ? 32'sd0 : integ_reg;
                end
                S_ACC:
                begin
                    prev_err_reg <= err_reg;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                target_reg   <= target_speed;
                neg_reg      <= delta[31];
                mag_reg      <= delta[31] ? -delta : delta;
                duty_res_reg <= '0;
                rev_res_reg  <= 1'b0;
                speed_reg    <= '0;
            end
            S_SPD_CHK:
            begin
                num_reg  <= prod_u[31:0];
                rsel_reg <= 1'b0;
                if (spd_sat)
                begin
                    raw_reg <= neg_reg ? -16'sd32768 : 16'sd32767;
                end
            end
            S_RHI:
            begin
                rlo_reg <= prod[48:0];
            end
            S_RFIN:
            begin
                if (rsel_reg)
                begin
                    speed_reg <= neg_reg ? 16'(-rq_s) : 16'(rq);
                end
                else if (!neg_reg)
                begin
                    raw_reg <= (rq > 17'd32767) ? 16'sd32767 : 16'(rq);
                end
                else
                begin
                    raw_reg <= (rq > 17'd32768) ? -16'sd32768 : 16'(-rq_s);
                end
            end
            S_AVG:
            begin
                neg_reg  <= sum_reg[SUMW-1];
                num_reg  <= 32'(sum_mag);
                rsel_reg <= 1'b1;
            end
            S_ERR:
            begin
                if (err_raw < band_s && err_raw > -band_s)
                begin
                    err_reg <= '0;
                end
                else
                begin
                    err_reg <= err_raw;
                end
            end
            S_IMUL:
            begin
                integ_reg <= integ_sat;
            end
            S_ICHK:
            begin
                neg_reg <= prod < -lim_s;
            end
            S_IDIV:
            begin
                integ_reg <= neg_reg ? 32'(-q_s33) : 32'(q_s33);
            end
            S_IFIN:
            begin
                if (target_reg == 16'sd0)
                begin
                    integ_reg <= '0;
                end
            end
            S_MI:   acc_reg <= prod;
            S_MD:   acc_reg <= acc_reg + prod;
            S_ACC:  acc_reg <= acc_reg + prod;
            S_OUT:
            begin
                duty_res_reg <= out_mag[21:12];
                rev_res_reg  <= out_c[22] && (out_mag[21:12] != 10'd0);
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    duty_reg <= duty_res_reg;
                    rev_reg  <= rev_res_reg;
                    meas_reg <= speed_reg;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req_type == REQ_STOP |=> integral_reg == 32'sd0)
    else $error("stop did not clear the integral");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_reverse |-> duty_magnitude != 10'd0)
    else $error("reverse drive with zero magnitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req_type == REQ_EDGE |=> pulse_reg != $past(pulse_reg))
    else $error("encoder edge did not move the counter");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_IDIV)
    else $error("divider finished outside a wait step");

endmodule
